[sv/assert_macros.svh]
// assertion macros used by the rtl file finder_run_ratio_check
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define FRRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every edge out of reset
`define FRRC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

[sv/frrc_pkg.sv]
// types and constants for the finder run ratio check
// no dependencies
`timescale 1ns / 1ps

package frrc_pkg;

    localparam int RUN_W = 12;

    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic             pattern_ok;
        logic [RUN_W-1:0] run_total;
        logic [RUN_W-1:0] longest_run;
    } out_item_t;

endpackage

[sv/finder_run_ratio_check.sv]
// finder run ratio check: top level, run tracking and verdict
// depends on frrc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// finder_run_ratio_check
// pix channel: one pixel of a scan line per item, zero is black and nonzero is
// white; line_end marks the last pixel of the line.
// res channel: one verdict item per line, sent after the line_end pixel, with
// pattern_ok, the run count and the length of the first longest run.
// both channels use valid/stall; an item moves when valid is high and stall
// is low.
// throughput: one pixel per cycle while pix_stall is low. each item passes an input
// register and is then folded into the run state by compare-and-update logic.
// verdict path: a line_end pixel is registered in in_reg, then its verdict in res_reg.
// stall: while a verdict waits in the output register the block keeps taking
// pixels; only a further line_end pixel waits in the input register, and the
// pix side stalls once that register is held.
// reset: clears all run state and both valid flags; the first pixel after
// reset starts a new line. run state also clears after every line_end.
module finder_run_ratio_check #(
    parameter int LINE_WIDTH = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  frrc_pkg::in_item_t  pix,
    output logic                res_valid,
    input  logic                res_stall,
    output frrc_pkg::out_item_t res
);

    localparam int RW          = frrc_pkg::RUN_W;
    localparam int RUN_CAP_INT = (LINE_WIDTH < 4095) ? LINE_WIDTH : 4095;
    localparam logic [RW-1:0] RUN_CAP = RW'(RUN_CAP_INT);

    typedef struct packed {
        logic          run_colour;
        logic [RW-1:0] run_length;
        logic [RW-1:0] previous_run;
        logic [RW-1:0] max_run;
        logic [RW-1:0] max_position;
        logic [RW-1:0] run_before_max;
        logic [RW-1:0] run_after_max;
        logic          after_captured;
        logic [RW-1:0] runs_closed;
    } run_state_t;

    function automatic run_state_t close_run(input run_state_t s, input logic [RW-1:0] len);
        run_state_t r;
        r = s;
        if (s.runs_closed >= RUN_CAP)
        begin
            r.previous_run = len;
        end
        else
        begin
            if (s.runs_closed == '0 || len > s.max_run)
            begin
                r.max_run        = len;
                r.max_position   = s.runs_closed;
                r.run_before_max = s.previous_run;
                r.run_after_max  = '0;
                r.after_captured = 1'b0;
            end
            else if (!s.after_captured
                     && {1'b0, s.runs_closed} == {1'b0, s.max_position} + (RW+1)'(1))
            begin
                r.run_after_max  = len;
                r.after_captured = 1'b1;
            end
            r.previous_run = len;
            r.runs_closed  = s.runs_closed + RW'(1);
        end
        return r;
    endfunction

    // exact form of 0.40 < 3*n/m < 2.25
    function automatic logic neighbour_ok(input logic [RW-1:0] n, input logic [RW-1:0] m);
        logic [RW+4:0] n15;
        logic [RW+4:0] m2;
        logic [RW+4:0] n4;
        logic [RW+4:0] m3;
        n15 = (RW+5)'(n) * (RW+5)'(15);
        m2  = (RW+5)'(m) * (RW+5)'(2);
        n4  = (RW+5)'(n) * (RW+5)'(4);
        m3  = (RW+5)'(m) * (RW+5)'(3);
        return (n15 > m2) && (n4 < m3);
    endfunction

    frrc_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    frrc_pkg::out_item_t res_reg;
    frrc_pkg::out_item_t res_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    run_state_t          st_reg;
    run_state_t          st_next;
    logic                advance;
    logic                res_free;

    assign res_free  = !res_valid_reg || !res_stall;
    // only a line end needs room in the output register
    assign advance   = in_valid_reg && (!in_reg.line_end || res_free);
    assign pix_stall = in_valid_reg && !advance;

    always_comb
    begin
        run_state_t s;
        logic       colour;
        logic       ok;
        s        = st_reg;
        colour   = |in_reg.pixel;
        ok       = 1'b0;
        res_next = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        st_next  = st_reg;
        if (advance)
        begin
            if (s.run_length == '0)
            begin
                s.run_colour = colour;
                s.run_length = RW'(1);
            end
            else if (colour != s.run_colour)
            begin
                s = close_run(s, s.run_length);
                s.run_colour = colour;
                s.run_length = RW'(1);
            end
            else if (s.run_length < RUN_CAP)
            begin
                s.run_length = s.run_length + RW'(1);
            end

            if (in_reg.line_end)
            begin
                s  = close_run(s, s.run_length);
                ok = (s.runs_closed >= RW'(5))
                    && (s.max_position >= RW'(2))
                    && s.after_captured
                    && (s.runs_closed - s.max_position >= RW'(3))
                    && neighbour_ok(s.run_before_max, s.max_run)
                    && neighbour_ok(s.run_after_max, s.max_run);
                res_next.pattern_ok  = ok;
                res_next.run_total   = s.runs_closed;
                res_next.longest_run = s.max_run;
                res_valid_next       = 1'b1;
                st_next              = '0;
            end
            else
            begin
                st_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (!pix_stall)
            begin
                in_valid_reg <= pix_valid;
            end
            res_valid_reg <= res_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && !pix_stall)
        begin
            in_reg <= pix;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `FRRC_ASSERT_IMP(a_stall_line_end, clk, rst_n, pix_stall,
        in_valid_reg && in_reg.line_end && res_valid_reg && res_stall,
        "pix stalled without a blocked line end")
    `FRRC_ASSERT_IMP(a_ok_runs, clk, rst_n, res_valid_reg && res_reg.pattern_ok,
        res_reg.run_total >= RW'(5) && res_reg.longest_run != '0,
        "pattern passed with too few runs")
    `FRRC_ASSERT_IMP(a_run_total, clk, rst_n, res_valid_reg, res_reg.run_total != '0,
        "verdict with no runs")
    `FRRC_ASSERT_ALWAYS(a_run_cap, clk, rst_n,
        st_reg.run_length <= RUN_CAP && st_reg.runs_closed <= RUN_CAP,
        "run counters past cap")

endmodule
